// ===== hw/rtl/rit_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function for the
// radix integer to ASCII converter. No dependencies.
`default_nettype none

package rit_pkg;

  // Input value width and digit store depth
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;

  // Port field widths
  localparam int IN_W    = 64;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;
  localparam int RADIX_W = 6;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int QW         = DIV_CYCLES * DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_CYCLES + 1);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0]  CH_ZERO      = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0]  CH_UPPER_OFS = CHAR_W'(55);  // 'A' - 10
  localparam logic [CHAR_W-1:0]  CH_LOWER_OFS = CHAR_W'(87);  // 'a' - 10
  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX = DIGIT_W'(9);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_OUT
  } rit_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(
    input logic [DIGIT_W-1:0] d,
    input logic               upper
  );
    logic [CHAR_W-1:0] ofs;
    if (d > DIGIT_DEC_MAX) begin
      ofs = upper ? CH_UPPER_OFS : CH_LOWER_OFS;
    end else begin
      ofs = CH_ZERO;
    end
    return CHAR_W'(d) + ofs;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rit_if.sv =====
// Valid/ready channel interfaces for the converter's value input and digit output.
// Depends on rit_pkg.
`default_nettype none

interface rit_in_if;
  import rit_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rit_out_if;
  import rit_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rit_div.sv =====
// Iterative divider by a small radix: DIV_BITS quotient bits per cycle,
// restoring compare/subtract on a 6-bit remainder. Depends on rit_pkg.
`default_nettype none

module rit_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rit_pkg::QW-1:0]      dividend,
  input  wire logic [rit_pkg::RADIX_W-1:0] divisor,
  output rit_pkg::div_stat_t               stat,
  output logic [rit_pkg::QW-1:0]           quotient,
  output logic [rit_pkg::DIGIT_W-1:0]      remainder
);
  import rit_pkg::*;

  logic [QW-1:0]      q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r, done_r;

  // One cycle's worth of shift/compare/subtract steps
  always_comb begin
    logic [DIGIT_W:0] t;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t     = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        rem_nxt  = DIGIT_W'(t - {1'b0, divisor});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(DIV_CYCLES);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rit_store.sv =====
// Digit store: MAX_DIGITS x 6-bit memory, one write and one registered read
// port. Depends on rit_pkg.
`default_nettype none

module rit_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [rit_pkg::IDX_W-1:0]   waddr,
  input  wire logic [rit_pkg::DIGIT_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [rit_pkg::IDX_W-1:0]   raddr,
  output logic [rit_pkg::DIGIT_W-1:0]      rdata
);
  import rit_pkg::*;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/radix_integer_to_ascii.sv =====
// Radix integer to ASCII converter, top level. Uses rit_pkg, rit_if, rit_div, rit_store.
// Operation: each digit is one pass of the shared divider, and its remainder is written to the
// digit store; digits are then read back most significant first, each through ST_RD and ST_OUT.
// One value at a time: a new value is accepted only in idle, after its last digit is taken.
// Reset: synchronous active-low; radix 10, upper case, idle. Digit store is not cleared.
`default_nettype none

module radix_integer_to_ascii (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rit_in_if.sink                             in_chan,
  rit_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rit_pkg::CFG_W-1:0]     cfg_data
);
  import rit_pkg::*;

  rit_state_t         state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic               upper_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   rp_r, rp_nxt;

  logic               div_start;
  logic [QW-1:0]      div_dividend;
  div_stat_t          div_stat;
  logic [QW-1:0]      div_quot;
  logic [DIGIT_W-1:0] div_rem;

  logic               st_we, st_re;
  logic [DIGIT_W-1:0] st_rdata;
  logic [CNT_W-1:0]   cnt_inc;

  // Configuration registers, radix clamped to 2..36
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      upper_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RADIX: begin
          if (cfg_data < RADIX_MIN) begin
            radix_r <= RADIX_MIN;
          end else if (cfg_data > RADIX_MAX) begin
            radix_r <= RADIX_MAX;
          end else begin
            radix_r <= cfg_data;
          end
        end
        CFG_UPPER: upper_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  rit_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rit_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (div_rem),
    .re    (st_re),
    .raddr (rp_r),
    .rdata (st_rdata)
  );

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rp_r    <= rp_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    div_start    = 1'b0;
    div_dividend = div_quot;
    st_we        = 1'b0;
    st_re        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        div_dividend = QW'(in_chan.value[VALUE_WIDTH-1:0]);
        if (in_chan.valid) begin
          div_start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          st_we   = 1'b1;
          cnt_nxt = cnt_inc;
          // keep dividing while a quotient is left and the store has room
          if (div_quot != '0 && cnt_inc < CNT_W'(MAX_DIGITS)) begin
            div_start = 1'b1;
          end else begin
            rp_nxt    = cnt_r[IDX_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        st_re     = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          if (rp_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rp_nxt    = rp_r - IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = (state_r == ST_OUT);
  assign out_chan.digit_char = digit_to_ascii(st_rdata, upper_r);
  assign out_chan.last_digit = (rp_r == '0);

endmodule

`default_nettype wire

// ===== tb/tb_radix_integer_to_ascii.sv =====
// Self-checking testbench for radix_integer_to_ascii: directed table, then random phases.
// Expected digit streams come from typed table strings or a local divide-by-radix predictor.
// Depends on rit_pkg, rit_if and the RTL top.
`timescale 1ns / 100ps

module tb_radix_integer_to_ascii;
  import rit_pkg::*;

  localparam int DIGIT_LIMIT = 64;
  localparam int RADIX_LO    = 2;
  localparam int RADIX_HI    = 36;
  localparam int DEC_TOP     = 9;
  localparam logic [CHAR_W-1:0] ASC_ZERO  = CHAR_W'("0");
  localparam logic [CHAR_W-1:0] ASC_UPPER = CHAR_W'("A") - CHAR_W'(10);
  localparam logic [CHAR_W-1:0] ASC_LOWER = CHAR_W'("a") - CHAR_W'(10);

  typedef enum logic {ROW_CFG, ROW_VALUE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic [IN_W-1:0]        value;
    string                  text;   // typed expectation; empty means use the predictor
  } dir_row_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [IN_W-1:0]      in_value  = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  rit_in_if  in_ch();
  rit_out_if out_ch();

  assign in_ch.valid  = in_valid;
  assign in_ch.value  = in_value;
  assign out_ch.ready = out_ready;

  radix_integer_to_ascii u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // register shadows
  int unsigned radix_m = 10;
  logic        upper_m = 1'b1;

  digit_t digits_q[$];
  int     err_cnt       = 0;
  int     in_gap_pct    = 0;
  int     out_stall_pct = 0;
  int     stall_left    = 0;

  dir_row_t dir_rows[] = '{
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd0,                  "0"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd9,                  "9"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd10,                 "10"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd12345678901234567890, ""},
    '{ROW_CFG,   CFG_RADIX, 6'd0,  64'd0,                  ""},   // clamps to 2
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd5,                  "101"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'h8000_0000_0000_0000, ""},
    '{ROW_CFG,   CFG_RADIX, 6'd1,  64'd0,                  ""},   // clamps to 2
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd1,                  "1"},
    '{ROW_CFG,   CFG_RADIX, 6'd63, 64'd0,                  ""},   // clamps to 36
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd35,                 "Z"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{ROW_CFG,   CFG_UPPER, 6'd0,  64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd35,                 "z"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd1295,               "zz"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd36,                 "10"},
    '{ROW_CFG,   CFG_RADIX, 6'd37, 64'd0,                  ""},   // clamps to 36
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd46655,              "zzz"},
    '{ROW_CFG,   CFG_RADIX, 6'd16, 64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hDEAD_BEEF_0123_4567, "deadbeef01234567"},
    '{ROW_CFG,   CFG_UPPER, 6'd1,  64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hABCD_EF00_0000_0009, "ABCDEF0000000009"},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'h0123_4567_89AB_CDEF, "123456789ABCDEF"},
    '{ROW_CFG,   CFG_RADIX, 6'd3,  64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{ROW_CFG,   CFG_RADIX, 6'd8,  64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd511,                "777"},
    '{ROW_CFG,   CFG_RADIX, 6'd36, 64'd0,                  ""},
    '{ROW_VALUE, CFG_RADIX, 6'd0,  64'd0,                  "0"}
  };

  // Divide by the shadowed radix, queue the digits most significant first.
  function automatic void predict_digits(input logic [IN_W-1:0] v);
    logic [IN_W-1:0]    q;
    logic [DIGIT_W-1:0] dig [DIGIT_LIMIT];
    int                 n;
    digit_t             d;
    q = v;
    n = 0;
    do begin
      dig[n] = DIGIT_W'(q % 64'(radix_m));
      q      = q / 64'(radix_m);
      n++;
    end while (q != 0 && n < DIGIT_LIMIT);
    for (int k = n - 1; k >= 0; k--) begin
      if (dig[k] > DEC_TOP) begin
        d.ch = CHAR_W'(dig[k]) + (upper_m ? ASC_UPPER : ASC_LOWER);
      end else begin
        d.ch = CHAR_W'(dig[k]) + ASC_ZERO;
      end
      d.last = (k == 0);
      digits_q.push_back(d);
    end
  endfunction

  // Leaves cfg_we high; the next send_value lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (digits_q.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_RADIX) begin
      radix_m = (data < RADIX_LO) ? RADIX_LO : (data > RADIX_HI) ? RADIX_HI : data;
    end else begin
      upper_m = data[0];
    end
  endtask

  // Returns at the edge where the request is taken.
  task automatic send_value(input logic [IN_W-1:0] v);
    int gap;
    cfg_we <= 1'b0;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : digit_check
    digit_t want;
    if (rst_n && out_ch.valid && out_ready) begin
      if (digits_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected digit, expected none, actual char %h last %b",
                 $time, out_ch.digit_char, out_ch.last_digit);
      end else begin
        want = digits_q.pop_front();
        if (out_ch.digit_char !== want.ch) begin
          err_cnt++;
          $display("%0t: digit_char expected %h actual %h", $time, want.ch, out_ch.digit_char);
        end
        if (out_ch.last_digit !== want.last) begin
          err_cnt++;
          $display("%0t: last_digit expected %b actual %b", $time, want.last,
                   out_ch.last_digit);
        end
      end
    end
  end

  initial begin : stim
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] p;
    int unsigned     k;
    int unsigned     pick;
    digit_t          d;

    in_gap_pct    = 15;
    out_stall_pct = 15;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_value(dir_rows[r].value);
        if (dir_rows[r].text.len() == 0) begin
          predict_digits(dir_rows[r].value);
        end else begin
          for (int i = 0; i < dir_rows[r].text.len(); i++) begin
            d.ch   = CHAR_W'(dir_rows[r].text[i]);
            d.last = (i == dir_rows[r].text.len() - 1);
            digits_q.push_back(d);
          end
        end
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      // last phase runs with both sides always ready
      if (phase == 7) begin
        in_gap_pct = 0;  out_stall_pct = 0;
      end else begin
        case (phase % 4)
          0: begin in_gap_pct = 5;  out_stall_pct = 25; end
          1: begin in_gap_pct = 25; out_stall_pct = 5;  end
          2: begin in_gap_pct = 0;  out_stall_pct = 0;  end
          default: begin in_gap_pct = 30; out_stall_pct = 30; end
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_RADIX, CFG_W'($urandom_range(0, 63)));
      end else begin
        write_reg(CFG_RADIX, CFG_W'($urandom_range(RADIX_LO, RADIX_HI)));
      end
      write_reg(CFG_UPPER, CFG_W'($urandom_range(0, 1)));

      for (int n = 0; n < 48; n++) begin
        pick = $urandom_range(0, 15);
        v    = {$urandom, $urandom};
        if (pick == 0) begin
          v = '1;
        end else if (pick == 1) begin
          v = '0;
        end else if (pick < 5) begin
          // land on or just under a power of the radix
          k = $urandom_range(1, 64);
          p = 64'd1;
          while (k != 0 && p <= 64'hFFFF_FFFF_FFFF_FFFF / 64'(radix_m)) begin
            p = p * 64'(radix_m);
            k--;
          end
          v = pick[0] ? p : p - 64'd1;
        end else begin
          k = $urandom_range(0, 64);
          if (k < 64) v = v & ((64'd1 << k) - 64'd1);
        end
        send_value(v);
        predict_digits(v);
      end
    end

    in_valid <= 1'b0;
    while (digits_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
